[rtl/core/srts_pkg.sv]
// ----------------------------------------------------------------------------
// srts_pkg: shared types and codes of the shortest remaining time scheduler
// Word formats of both channels, command codes, slot state codes and the
// command and status groups between the controller and the datapath.
// ----------------------------------------------------------------------------
package srts_pkg;

  // Command codes of an input word.
  localparam logic [2:0] K_ADMIT    = 3'd0;
  localparam logic [2:0] K_PICK     = 3'd1;
  localparam logic [2:0] K_RELEASE  = 3'd2;
  localparam logic [2:0] K_WAKE     = 3'd3;
  localparam logic [2:0] K_GIVE_WAY = 3'd4;
  localparam logic [2:0] K_FREE     = 3'd5;

  // Slot state codes.
  localparam logic [2:0] ST_UNUSED   = 3'd0;
  localparam logic [2:0] ST_RUNNABLE = 3'd1;
  localparam logic [2:0] ST_RUNNING  = 3'd2;
  localparam logic [2:0] ST_SLEEPING = 3'd3;
  localparam logic [2:0] ST_FINISHED = 3'd4;

  // State requested by a release.
  localparam logic [1:0] NS_RUNNABLE = 2'd0;
  localparam logic [1:0] NS_SLEEPING = 2'd1;

  typedef struct packed {
    logic [2:0]         kind;
    logic [5:0]         slot;
    logic [30:0]        task_id;
    logic signed [31:0] remaining_in;
    logic [1:0]         next_state;
    logic [31:0]        now_tick;
  } in_item_t;

  typedef struct packed {
    logic               found;
    logic [5:0]         chosen_slot;
    logic [30:0]        chosen_id;
    logic signed [31:0] remaining_out;
  } out_item_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;      // capture the input word, restart the scan
    logic rd_slot;   // read the tables at the addressed slot
    logic scan;      // read the tables at the scan index and advance it
    logic calc;      // compute the elapsed ticks of the addressed slot
    logic apply;     // update the addressed slot and issue its result
    logic pick_fin;  // commit the chosen slot and issue its result
  } srts_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic is_pick;
    logic scan_last;
  } srts_status_t;

endpackage

[rtl/core/shortest_remaining_time_scheduler_top.sv]
// ----------------------------------------------------------------------------
// shortest_remaining_time_scheduler_top: task slot scheduler
// Admits, picks, charges, wakes, gives way and frees task slots; a pick
// returns the runnable slot with the smallest remaining time, preferring slots that have not given way.
// ----------------------------------------------------------------------------
// A word is taken when start is high and busy is low; every word yields one
// result, shown on out_item for a single cycle with out_valid high, and the
// receiver cannot stall it, so it must take each result in that cycle.
// Admit, release, wake, give way and free pass through a table read, the
// elapsed tick subtraction, then the saturating charge and update; the result
// strobe is registered from the update. A pick scans the slot table through
// the single memory read port at one slot per cycle, then commits the winner.
// The slot memories need no clearing after reset, so a word can be taken in
// the first cycle.
module shortest_remaining_time_scheduler_top #(
  parameter int SLOTS = 64
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  srts_pkg::in_item_t  in_item,
  output logic                out_valid,
  output srts_pkg::out_item_t out_item
);
  import srts_pkg::*;

  srts_cmd_t    cmd;
  srts_status_t status;

  // Sequencing controller.
  srts_ctrl u_ctrl (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .status (status),
    .cmd    (cmd),
    .busy   (busy)
  );

  // Slot tables and arithmetic.
  srts_dp #(
    .SLOTS (SLOTS)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_item   (in_item),
    .cmd       (cmd),
    .status    (status),
    .out_valid (out_valid),
    .out_item  (out_item)
  );

`ifndef SYNTHESIS
  // An accepted word always makes the block busy in the next cycle.
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("accepted word did not raise busy");

  // Each finishing command produces exactly one result strobe.
  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.apply || cmd.pick_fin) |=> out_valid)
    else $error("finished word gave no result");

  // A result only appears right after the block was busy.
  a_result_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(busy))
    else $error("result without a word in flight");

  // The controller issues at most one command per cycle.
  a_cmd_onehot: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({cmd.load, cmd.rd_slot, cmd.scan, cmd.calc, cmd.apply, cmd.pick_fin}))
    else $error("overlapping controller commands");
`endif

endmodule

[rtl/core/srts_ctrl.sv]
// ----------------------------------------------------------------------------
// srts_ctrl: sequencing controller of the scheduler
// Walks each accepted word through decode, table scan or read, update and
// result, issuing at most one command per cycle to the datapath.
// ----------------------------------------------------------------------------
module srts_ctrl (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  input  srts_pkg::srts_status_t status,
  output srts_pkg::srts_cmd_t    cmd,
  output logic                  busy
);
  import srts_pkg::*;

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_DECODE = 3'd1;
  localparam logic [2:0] S_SCAN   = 3'd2;
  localparam logic [2:0] S_DRAIN  = 3'd3;
  localparam logic [2:0] S_PICK   = 3'd4;
  localparam logic [2:0] S_CALC   = 3'd5;
  localparam logic [2:0] S_APPLY  = 3'd6;

  logic [2:0] state_r;
  logic [2:0] state_nxt;

  // Next state and command decode.
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          cmd.load  = 1'b1;
          state_nxt = S_DECODE;
        end
      end
      S_DECODE: begin
        cmd.rd_slot = 1'b1;
        state_nxt   = status.is_pick ? S_SCAN : S_CALC;
      end
      S_SCAN: begin
        cmd.scan = 1'b1;
        if (status.scan_last) begin
          state_nxt = S_DRAIN;
        end
      end
      S_DRAIN: begin
        state_nxt = S_PICK;
      end
      S_PICK: begin
        cmd.pick_fin = 1'b1;
        state_nxt    = S_IDLE;
      end
      S_CALC: begin
        cmd.calc  = 1'b1;
        state_nxt = S_APPLY;
      end
      S_APPLY: begin
        cmd.apply = 1'b1;
        state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // State register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign busy = (state_r != S_IDLE);

endmodule

[rtl/core/srts_dp.sv]
// ----------------------------------------------------------------------------
// srts_dp: slot tables, scan comparator and charge arithmetic
// Holds the per-slot state, marks and the remaining time, id and start tick
// memories; scans one slot per cycle for a pick and updates one slot per word.
// ----------------------------------------------------------------------------
module srts_dp #(
  parameter int SLOTS = 64
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  srts_pkg::in_item_t     in_item,
  input  srts_pkg::srts_cmd_t    cmd,
  output srts_pkg::srts_status_t status,
  output logic                   out_valid,
  output srts_pkg::out_item_t    out_item
);
  import srts_pkg::*;

  localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;

  // True when candidate a is preferred over the best so far b.
  function automatic logic better(input logic signed [31:0] ra, input logic [30:0] ia,
                                  input logic signed [31:0] rb, input logic [30:0] ib);
    logic res;
    if (ra != rb) begin
      res = (ra < rb);
    end else begin
      res = (ia > ib);
    end
    return res;
  endfunction

  // Captured input word.
  in_item_t item_r;

  // Per-slot state and marks, cleared by reset.
  logic [SLOTS-1:0][2:0] st_r, st_nxt;
  logic [SLOTS-1:0]      skip_r, skip_nxt;
  logic [SLOTS-1:0]      ran_r, ran_nxt;
  logic                  tv_r, tv_nxt;
  logic [IW-1:0]         tgt_r, tgt_nxt;

  // Slot memories, contents undefined until admitted.
  logic signed [31:0] rem_mem  [SLOTS];
  logic [30:0]        id_mem   [SLOTS];
  logic [31:0]        tick_mem [SLOTS];
  logic signed [31:0] rem_q;
  logic [30:0]        id_q;
  logic [31:0]        tick_q;

  logic [IW-1:0] rd_addr;
  logic          rd_en;
  logic          rem_we, id_we, tick_we;
  logic signed [31:0] rem_wd;

  // Scan index and the one-deep compare pipeline.
  logic [IW-1:0] scan_idx_r;
  logic          pv_r;
  logic [IW-1:0] pidx_r;
  logic          pall_r, pex_r;

  // Best candidates: excluding the skipped slots, and over all runnable slots.
  logic               hex_r, hall_r;
  logic [IW-1:0]      bex_idx_r, ball_idx_r;
  logic signed [31:0] bex_rem_r, ball_rem_r;
  logic [30:0]        bex_id_r, ball_id_r;

  // Charge arithmetic.
  logic [31:0]        elapsed_r;
  logic signed [32:0] diff;
  logic signed [31:0] charged;

  // Result register.
  logic      out_valid_r, out_valid_nxt;
  out_item_t out_item_r, out_item_nxt;

  logic               slot_ok;
  logic [IW-1:0]      slot_idx;
  logic               found;
  logic [IW-1:0]      sel_idx;
  logic signed [31:0] sel_rem;
  logic [30:0]        sel_id;
  logic               cand_all, cand_ex;

  assign slot_ok  = (32'(item_r.slot) < 32'(SLOTS));
  assign slot_idx = IW'(item_r.slot);

  assign status.is_pick   = (item_r.kind == K_PICK);
  assign status.scan_last = (scan_idx_r == IW'(SLOTS - 1));

  // Memory read port: scan index during a pick, addressed slot otherwise.
  assign rd_en   = cmd.scan | cmd.rd_slot;
  assign rd_addr = cmd.scan ? scan_idx_r : slot_idx;

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rem_q  <= rem_mem[rd_addr];
      id_q   <= id_mem[rd_addr];
      tick_q <= tick_mem[rd_addr];
    end
    if (rem_we) begin
      rem_mem[slot_idx] <= rem_wd;
    end
    if (id_we) begin
      id_mem[slot_idx] <= item_r.task_id;
    end
    if (tick_we) begin
      tick_mem[sel_idx] <= item_r.now_tick;
    end
  end

  // Eligibility of the slot under the scan index.
  assign cand_all = (st_r[scan_idx_r] == ST_RUNNABLE);
  assign cand_ex  = cand_all && !skip_r[scan_idx_r] && !(tv_r && (tgt_r == scan_idx_r));

  // Winner of the pick.
  assign found   = hex_r | hall_r;
  assign sel_idx = hex_r ? bex_idx_r : ball_idx_r;
  assign sel_rem = hex_r ? bex_rem_r : ball_rem_r;
  assign sel_id  = hex_r ? bex_id_r  : ball_id_r;

  // Remaining time minus elapsed ticks, saturated to 32 bits.
  assign diff = {rem_q[31], rem_q} - {elapsed_r[31], elapsed_r};
  always_comb begin
    if (diff[32] != diff[31]) begin
      charged = diff[32] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
    end else begin
      charged = diff[31:0];
    end
  end

  // Table updates and result formation.
  always_comb begin
    st_nxt        = st_r;
    skip_nxt      = skip_r;
    ran_nxt       = ran_r;
    tv_nxt        = tv_r;
    tgt_nxt       = tgt_r;
    rem_we        = 1'b0;
    id_we         = 1'b0;
    tick_we       = 1'b0;
    rem_wd        = item_r.remaining_in;
    out_valid_nxt = 1'b0;
    out_item_nxt  = out_item_r;

    if (cmd.pick_fin) begin
      out_valid_nxt = 1'b1;
      out_item_nxt  = '0;
      if (found) begin
        // Choosing anyone other than the target uses up its skip.
        if (tv_r && (sel_idx != tgt_r)) begin
          skip_nxt[tgt_r] = 1'b0;
          tv_nxt          = 1'b0;
        end
        st_nxt[sel_idx]            = ST_RUNNING;
        ran_nxt[sel_idx]           = 1'b1;
        tick_we                    = 1'b1;
        out_item_nxt.found         = 1'b1;
        out_item_nxt.chosen_slot   = 6'(sel_idx);
        out_item_nxt.chosen_id     = sel_id;
        out_item_nxt.remaining_out = sel_rem;
      end
    end else if (cmd.apply) begin
      out_valid_nxt               = 1'b1;
      out_item_nxt                = '0;
      out_item_nxt.chosen_slot    = item_r.slot;
      if (slot_ok) begin
        out_item_nxt.chosen_id     = id_q;
        out_item_nxt.remaining_out = rem_q;
        unique case (item_r.kind)
          K_ADMIT: begin
            st_nxt[slot_idx]           = ST_RUNNABLE;
            skip_nxt[slot_idx]         = 1'b0;
            ran_nxt[slot_idx]          = 1'b0;
            rem_we                     = 1'b1;
            id_we                      = 1'b1;
            out_item_nxt.chosen_id     = item_r.task_id;
            out_item_nxt.remaining_out = item_r.remaining_in;
          end
          K_RELEASE: begin
            if (st_r[slot_idx] == ST_RUNNING) begin
              if (ran_r[slot_idx]) begin
                rem_we                     = 1'b1;
                rem_wd                     = charged;
                out_item_nxt.remaining_out = charged;
              end
              case (item_r.next_state)
                NS_RUNNABLE: st_nxt[slot_idx] = ST_RUNNABLE;
                NS_SLEEPING: st_nxt[slot_idx] = ST_SLEEPING;
                default:     st_nxt[slot_idx] = ST_FINISHED;
              endcase
            end
          end
          K_WAKE: begin
            if (st_r[slot_idx] == ST_SLEEPING) begin
              st_nxt[slot_idx] = ST_RUNNABLE;
            end
          end
          K_GIVE_WAY: begin
            // A previous target loses its mark before the new one is set.
            if (tv_r) begin
              skip_nxt[tgt_r] = 1'b0;
            end
            skip_nxt[slot_idx] = 1'b1;
            tv_nxt             = 1'b1;
            tgt_nxt            = slot_idx;
          end
          K_FREE: begin
            st_nxt[slot_idx]   = ST_UNUSED;
            skip_nxt[slot_idx] = 1'b0;
            ran_nxt[slot_idx]  = 1'b0;
            if (tv_r && (tgt_r == slot_idx)) begin
              tv_nxt = 1'b0;
            end
          end
          default: begin
          end
        endcase
      end
    end
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= {SLOTS{ST_UNUSED}};
      skip_r      <= '0;
      ran_r       <= '0;
      tv_r        <= 1'b0;
      tgt_r       <= '0;
      pv_r        <= 1'b0;
      hex_r       <= 1'b0;
      hall_r      <= 1'b0;
      scan_idx_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      st_r        <= st_nxt;
      skip_r      <= skip_nxt;
      ran_r       <= ran_nxt;
      tv_r        <= tv_nxt;
      tgt_r       <= tgt_nxt;
      pv_r        <= cmd.scan;
      out_valid_r <= out_valid_nxt;
      if (cmd.load) begin
        scan_idx_r <= '0;
        hex_r      <= 1'b0;
        hall_r     <= 1'b0;
      end else begin
        if (cmd.scan) begin
          scan_idx_r <= scan_idx_r + 1'b1;
        end
        // Equal times favour the larger id; full ties keep the lower slot.
        if (pv_r && pex_r && (!hex_r || better(rem_q, id_q, bex_rem_r, bex_id_r))) begin
          hex_r <= 1'b1;
        end
        if (pv_r && pall_r && (!hall_r || better(rem_q, id_q, ball_rem_r, ball_id_r))) begin
          hall_r <= 1'b1;
        end
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      item_r <= in_item;
    end
    if (cmd.calc) begin
      elapsed_r <= item_r.now_tick - tick_q;
    end
    pidx_r     <= scan_idx_r;
    pall_r     <= cand_all;
    pex_r      <= cand_ex;
    out_item_r <= out_item_nxt;
    if (pv_r && pex_r && (!hex_r || better(rem_q, id_q, bex_rem_r, bex_id_r))) begin
      bex_idx_r <= pidx_r;
      bex_rem_r <= rem_q;
      bex_id_r  <= id_q;
    end
    if (pv_r && pall_r && (!hall_r || better(rem_q, id_q, ball_rem_r, ball_id_r))) begin
      ball_idx_r <= pidx_r;
      ball_rem_r <= rem_q;
      ball_id_r  <= id_q;
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

endmodule
